// ----- src/mmq_pkg.sv -----
// Package: shared types, sizes and codes for the message match queue.
package mmq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int FIFO_DEPTH = 2;

    localparam logic [1:0] OP_INSERT     = 2'd0;
    localparam logic [1:0] OP_TAKE_CALL  = 2'd1;
    localparam logic [1:0] OP_TAKE_REPLY = 2'd2;
    localparam logic [1:0] OP_TAKE_LAST  = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_OVFL = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        call_valid;
        logic        call_is_answer;
        logic [31:0] call_method;
        logic [31:0] call_id;
        logic [31:0] search_key;
    } mmq_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        out_valid;
        logic        out_is_answer;
        logic [31:0] out_method;
        logic [31:0] out_id;
        logic        takeover_seen;
        logic [4:0]  fill_level;
    } mmq_rsp_t;

    typedef struct packed {
        logic        valid;
        logic        answer;
        logic [31:0] method;
        logic [31:0] id;
    } mmq_slot_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } mmq_state_t;

endpackage

// ----- src/mmq_front.sv -----
// Front end: accepts transactions and queues them for the execution engine.
module mmq_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mmq_pkg::mmq_req_t req,
    output logic             cmd_valid,
    input  logic             cmd_pop,
    output mmq_pkg::mmq_req_t cmd
);
    import mmq_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    mmq_req_t            buf_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]   count_reg, count_next;
    logic                push, pop;

    assign busy      = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = buf_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = FCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = FCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= req;
        end
    end

endmodule

// ----- src/mmq_back.sv -----
// Back end: entry storage, head-to-tail search walk with compaction.
module mmq_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  mmq_pkg::mmq_req_t cmd,
    output logic              done,
    output mmq_pkg::mmq_rsp_t rsp
);
    import mmq_pkg::*;

    mmq_slot_t          slot_reg [DEPTH];
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   pt_reg, pt_next;
    mmq_state_t         state_reg, state_next;
    logic               by_reply_reg, by_reply_next;
    logic [31:0]        key_reg, key_next;
    logic               takeover_reg, takeover_next;
    logic               done_reg, done_next;
    mmq_rsp_t           rsp_reg, rsp_next;

    logic               ins_we;
    mmq_slot_t          ins_slot;
    logic               drop;
    mmq_slot_t          cur;
    mmq_slot_t          last;
    logic               hit;

    assign cur  = slot_reg[pt_reg[IDX_W-1:0]];
    assign last = slot_reg[IDX_W'(total_reg - 1'b1)];

    // reply: key 0 takes anything; call: non-answer only
    assign hit = by_reply_reg
               ? ((key_reg == '0) || (cur.answer && (cur.id == key_reg)))
               : (!cur.answer && ((key_reg == '0) || (cur.method == key_reg)));

    assign ins_slot = '{valid: cmd.call_valid, answer: cmd.call_is_answer,
                        method: cmd.call_method, id: cmd.call_id};

    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        pt_next       = pt_reg;
        by_reply_next = by_reply_reg;
        key_next      = key_reg;
        takeover_next = takeover_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        cmd_pop       = 1'b0;
        ins_we        = 1'b0;
        drop          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    rsp_next = '0;
                    rsp_next.status = STAT_MISS;
                    case (cmd.opcode)
                        OP_INSERT:
                        begin
                            done_next = 1'b1;
                            if (total_reg >= CNT_W'(DEPTH))
                            begin
                                rsp_next.status = STAT_OVFL;
                                rsp_next.fill_level = 5'(total_reg);
                            end
                            else
                            begin
                                ins_we = 1'b1;
                                total_next = CNT_W'(total_reg + 1'b1);
                                rsp_next.status = STAT_OK;
                                rsp_next.fill_level = 5'(total_next);
                            end
                        end
                        OP_TAKE_LAST:
                        begin
                            done_next = 1'b1;
                            if (total_reg != '0)
                            begin
                                total_next = CNT_W'(total_reg - 1'b1);
                                rsp_next.status        = STAT_OK;
                                rsp_next.out_valid     = last.valid;
                                rsp_next.out_is_answer = last.answer;
                                rsp_next.out_method    = last.method;
                                rsp_next.out_id        = last.id;
                            end
                            rsp_next.fill_level = 5'(total_next);
                        end
                        default:
                        begin
                            state_next    = ST_WALK;
                            pt_next       = '0;
                            by_reply_next = (cmd.opcode == OP_TAKE_REPLY);
                            key_next      = cmd.search_key;
                            takeover_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                rsp_next = '0;
                if (pt_reg >= total_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    rsp_next.status        = STAT_MISS;
                    rsp_next.takeover_seen = takeover_reg;
                    rsp_next.fill_level    = 5'(total_reg);
                end
                else if (hit)
                begin
                    drop       = 1'b1;
                    total_next = CNT_W'(total_reg - 1'b1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    rsp_next.status        = STAT_OK;
                    rsp_next.out_valid     = cur.valid;
                    rsp_next.out_is_answer = cur.answer;
                    rsp_next.out_method    = cur.method;
                    rsp_next.out_id        = cur.id;
                    rsp_next.takeover_seen = takeover_reg;
                    rsp_next.fill_level    = 5'(total_next);
                end
                else if (!cur.valid)
                begin
                    drop          = 1'b1;
                    total_next    = CNT_W'(total_reg - 1'b1);
                    takeover_next = 1'b1;
                    rsp_next      = rsp_reg;
                end
                else
                begin
                    pt_next  = CNT_W'(pt_reg + 1'b1);
                    rsp_next = rsp_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            pt_reg       <= '0;
            takeover_reg <= 1'b0;
            done_reg     <= 1'b0;
            by_reply_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            pt_reg       <= pt_next;
            takeover_reg <= takeover_next;
            done_reg     <= done_next;
            by_reply_reg <= by_reply_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

    // removal shifts every entry above the walk pointer down by one
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            if (drop && (CNT_W'(k) >= pt_reg) && (k < DEPTH - 1))
            begin
                slot_reg[k] <= slot_reg[(k < DEPTH - 1) ? k + 1 : k];
            end
            else if (ins_we && (CNT_W'(k) == total_reg))
            begin
                slot_reg[k] <= ins_slot;
            end
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- src/message_match_queue.sv -----
// Top level: message match queue, front queue plus execution back end.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------
//  request   | start / busy       | req  (mmq_req_t)
//  result    | done (one cycle)   | rsp  (mmq_rsp_t)
//
//  A transaction is taken on a clock edge with start high and busy low and
//  lands in a two-entry command queue; busy is high only while it is full.
//  With the back end idle, an insert or take-last is popped from the command
//  queue and its result is registered. A search walks the entries from the
//  head, dropping invalid ones, until a hit or the end of the fill level;
//  queued transactions wait behind it.
//  Reset (rst_n low, async) empties the queue and the command buffer.
//  done is a one-cycle strobe; the receiver cannot stall it.
module message_match_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mmq_pkg::mmq_req_t req,
    output logic              done,
    output mmq_pkg::mmq_rsp_t rsp
);
    import mmq_pkg::*;

    logic     cmd_valid;
    logic     cmd_pop;
    mmq_req_t cmd;

    // front: classifies nothing yet, just buffers transactions
    mmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // back: storage, walk, compaction, result register
    mmq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

// ----- src/mmq_checker.sv -----
// Checker: port-level properties of the message match queue, bound to the top.
module mmq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              done,
    input mmq_pkg::mmq_rsp_t rsp
);
    import mmq_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == STAT_OK || rsp.status == STAT_MISS ||
                  rsp.status == STAT_OVFL))
        else $error("bad status code");

    a_ovfl_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == STAT_OVFL) |-> (rsp.fill_level == 5'(DEPTH)))
        else $error("overflow while not full");

    a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != STAT_OK) |->
            (!rsp.out_valid && !rsp.out_is_answer && rsp.out_method == '0
             && rsp.out_id == '0))
        else $error("entry returned without success");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.fill_level <= 5'(DEPTH)))
        else $error("fill level out of range");

    a_idle_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !done)
        else $error("result right after reset");

endmodule

bind message_match_queue mmq_checker u_mmq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .done  (done),
    .rsp   (rsp)
);

// ----- dv/message_match_queue_test.sv -----
// Testbench for message_match_queue: queued driver, strobe monitor, in-bench queue predictor.
module message_match_queue_test;
    import mmq_pkg::*;

    // Idle phases of the sender: none, 47 of a hundred, 7 of a hundred, none.
    localparam int WATCHDOG_LIMIT = 2000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    mmq_req_t  req;
    logic      done;
    mmq_rsp_t  rsp;

    // busy as seen at the last rising edge, so the driver knows what was taken.
    logic      busy_q;

    message_match_queue i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // Pending transactions waiting for the driver, and responses owed by the block.
    mmq_req_t  pending_reqs[$];
    mmq_rsp_t  owed_rsps[$];

    // Shadow copy of the queue contents, oldest entry at index 0.
    mmq_slot_t shadow_slots[$];

    int        error_count = 0;
    int        idle_pct;
    int        quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Predict the response of one transaction and update the shadow queue.
    function automatic mmq_rsp_t predict_queue_op(mmq_req_t r);
        mmq_rsp_t  p;
        mmq_slot_t s;
        int        pos;
        bit        hit;
        p = '0;
        p.status = STAT_MISS;
        case (r.opcode)
            OP_INSERT:
            begin
                if (shadow_slots.size() >= DEPTH)
                    p.status = STAT_OVFL;
                else
                begin
                    s.valid  = r.call_valid;
                    s.answer = r.call_is_answer;
                    s.method = r.call_method;
                    s.id     = r.call_id;
                    shadow_slots.push_back(s);
                    p.status = STAT_OK;
                end
            end
            OP_TAKE_LAST:
            begin
                if (shadow_slots.size() > 0)
                begin
                    s = shadow_slots.pop_back();
                    p.status        = STAT_OK;
                    p.out_valid     = s.valid;
                    p.out_is_answer = s.answer;
                    p.out_method    = s.method;
                    p.out_id        = s.id;
                end
            end
            default:
            begin
                pos = 0;
                while (pos < shadow_slots.size())
                begin
                    s = shadow_slots[pos];
                    // key 0 is a wildcard; reply wildcard even takes calls
                    if (r.opcode == OP_TAKE_REPLY)
                        hit = (r.search_key == 0) || (s.answer && s.id == r.search_key);
                    else
                        hit = !s.answer && (r.search_key == 0 || s.method == r.search_key);
                    if (hit)
                    begin
                        shadow_slots.delete(pos);
                        p.status        = STAT_OK;
                        p.out_valid     = s.valid;
                        p.out_is_answer = s.answer;
                        p.out_method    = s.method;
                        p.out_id        = s.id;
                        break;
                    end
                    if (!s.valid)
                    begin
                        // stale entry dropped on the way: takeover
                        shadow_slots.delete(pos);
                        p.takeover_seen = 1'b1;
                    end
                    else
                        pos++;
                end
            end
        endcase
        p.fill_level = 5'(shadow_slots.size());
        return p;
    endfunction

    function automatic mmq_req_t make_req(logic [1:0] op, int v, int a,
                                          logic [31:0] m, logic [31:0] id,
                                          logic [31:0] key);
        mmq_req_t r;
        r.opcode         = op;
        r.call_valid     = 1'(v);
        r.call_is_answer = 1'(a);
        r.call_method    = m;
        r.call_id        = id;
        r.search_key     = key;
        return r;
    endfunction

    // Small pools of methods and ids make hits frequent; full range as noise.
    function automatic logic [31:0] pick_tag();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return $urandom_range(1, 5);
    endfunction

    function automatic mmq_req_t random_req();
        int          sel;
        logic [1:0]  op;
        logic [31:0] key;
        sel = $urandom_range(0, 99);
        if (sel < 45)      op = OP_INSERT;
        else if (sel < 70) op = OP_TAKE_CALL;
        else if (sel < 92) op = OP_TAKE_REPLY;
        else               op = OP_TAKE_LAST;
        key = ($urandom_range(0, 7) == 0) ? 32'd0 : pick_tag();
        return make_req(op, ($urandom_range(0, 5) != 0) ? 1 : 0,
                        int'($urandom_range(0, 1)), pick_tag(), pick_tag(), key);
    endfunction

    // Driver: presents the head of the pending queue at the falling edge.
    // A transaction is taken at the rising edge with start high and busy low.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            if (start && !busy_q)
                pending_reqs.pop_front();
            if (pending_reqs.size() > 0 && ($urandom_range(0, 99) >= idle_pct))
            begin
                start <= 1'b1;
                req   <= pending_reqs[0];
            end
            else
            begin
                start <= 1'b0;
                req   <= random_req();
            end
        end
    end

    always @(posedge clk)
        busy_q <= busy;

    // Monitor: predicts on acceptance, checks every done strobe.
    always @(posedge clk)
    begin
        mmq_rsp_t exp_rsp;
        bit       active;
        if (rst_n)
        begin
            active = 1'b0;
            if (start && !busy)
            begin
                owed_rsps.push_back(predict_queue_op(req));
                active = 1'b1;
            end
            if (done)
            begin
                active = 1'b1;
                if (owed_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response %p", $time, rsp);
                    error_count++;
                end
                else
                begin
                    exp_rsp = owed_rsps.pop_front();
                    if (rsp.status !== exp_rsp.status ||
                        rsp.out_valid !== exp_rsp.out_valid ||
                        rsp.out_is_answer !== exp_rsp.out_is_answer ||
                        rsp.out_method !== exp_rsp.out_method ||
                        rsp.out_id !== exp_rsp.out_id ||
                        rsp.takeover_seen !== exp_rsp.takeover_seen ||
                        rsp.fill_level !== exp_rsp.fill_level)
                    begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_rsp, rsp);
                        error_count++;
                    end
                end
            end
            if (active)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || owed_rsps.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int k;
        idle_pct = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty take-last, empty searches, extremes, overflow,
        // invalid matches, takeover sweep, reply wildcard on a call.
        pending_reqs.push_back(make_req(OP_TAKE_LAST, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_TAKE_CALL, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_TAKE_REPLY, 0, 0, 0, 0, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(OP_INSERT, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        pending_reqs.push_back(make_req(OP_INSERT, 0, 0, 0, 0, 32'hFFFF_FFFF));
        for (k = 0; k < 15; k++)
            pending_reqs.push_back(make_req(OP_INSERT, (k % 3 != 0) ? 1 : 0, k % 2,
                                            k, k + 7, 0));
        pending_reqs.push_back(make_req(OP_INSERT, 1, 0, 1, 1, 0));
        pending_reqs.push_back(make_req(OP_TAKE_CALL, 0, 0, 0, 0, 32'hDEAD_BEEF));
        pending_reqs.push_back(make_req(OP_TAKE_REPLY, 0, 0, 0, 0, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(OP_TAKE_REPLY, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_TAKE_CALL, 0, 0, 0, 0, 0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 47 : (ph == 2) ? 7 : 0;
            for (k = 0; k < 275; k++)
                pending_reqs.push_back(random_req());
            wait_drained();
        end
        repeat (DEPTH + 10) @(posedge clk);
        if (error_count == 0 && owed_rsps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- sim.f -----
src/mmq_pkg.sv
src/mmq_front.sv
src/mmq_back.sv
src/message_match_queue.sv
src/mmq_checker.sv
dv/message_match_queue_test.sv
